@@ hw/rtl/elcs_pkg.sv @@
`timescale 1ns / 1ps
package elcs_pkg;
   localparam int NODES_DEF      = 65536;
   localparam int COUNT_BITS_DEF = 20;

   localparam int NODE_W   = 17;
   localparam int INDEX_W  = 16;
   localparam int SLOT_W   = 20;
   localparam int WEIGHT_W = 17;
   localparam int DAMP_W   = 16;

   localparam logic [1:0] OP_COUNT  = 2'd0;
   localparam logic [1:0] OP_PLACE  = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic KIND_ENTRY  = 1'b0;
   localparam logic KIND_DEGREE = 1'b1;

   localparam logic REG_DAMPING = 1'b0;
   localparam logic [DAMP_W-1:0] DAMPING_RESET = 16'd55706;
endpackage

@@ hw/rtl/elcs_div.sv @@
`timescale 1ns / 1ps
module elcs_div #(
   parameter int NUM_BITS   = 21,
   parameter int COUNT_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_BITS-1:0]   num,
   input  logic [COUNT_BITS-1:0] den,
   output logic                  done,
   output logic [NUM_BITS-1:0]   quot
);
   localparam int CW = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

   logic                  run_ff, done_ff;
   logic [CW-1:0]         cnt_ff;
   logic [NUM_BITS-1:0]   num_ff, quot_ff;
   logic [COUNT_BITS-1:0] rem_ff, den_ff, rem_in;
   logic [COUNT_BITS:0]   trial;
   logic                  ge;

   // one quotient bit per cycle, restoring
   assign trial  = {rem_ff, num_ff[NUM_BITS-1]};
   assign ge     = trial >= {1'b0, den_ff};
   assign rem_in = ge ? COUNT_BITS'(trial - {1'b0, den_ff}) : COUNT_BITS'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            if (cnt_ff == CW'(NUM_BITS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         den_ff  <= den;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (run_ff) begin
         num_ff  <= {num_ff[NUM_BITS-2:0], 1'b0};
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[NUM_BITS-2:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

@@ hw/rtl/edge_list_to_column_sparse.sv @@
`timescale 1ns / 1ps
// channel   | ports                                  | transfer
// ----------+----------------------------------------+---------------------------------
// request   | start, busy, req_*                     | start high while busy low
// response  | rsp_valid, rsp_*                       | rsp_valid high, one cycle, no stall
// csr       | psel, penable, pwrite, paddr, pwdata.. | access phase with pready high
//
// a query, or a place with an error, is answered out of the update state; a place
// that divides is answered when elcs_div is done (one quotient bit per cycle in elcs_div);
// a count gives no response; one item is in flight at a time
// after reset the degree memories are swept to zero, one entry per cycle, with busy
// high until all NODES entries are cleared
// the receiver cannot stall; each response shows for exactly one cycle
module edge_list_to_column_sparse
   import elcs_pkg::*;
#(
   parameter int NODES      = NODES_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic [NODE_W-1:0]          req_src_node,
   input  logic [NODE_W-1:0]          req_dst_node,
   input  logic [NODE_W-1:0]          req_query_node,
   output logic                       rsp_valid,
   output logic                       rsp_kind,
   output logic [INDEX_W-1:0]         rsp_row_index,
   output logic [SLOT_W-1:0]          rsp_slot,
   output logic [INDEX_W-1:0]         rsp_column_index,
   output logic signed [WEIGHT_W-1:0] rsp_weight,
   output logic [SLOT_W-1:0]          rsp_in_degree,
   output logic                       rsp_error,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int C  = COUNT_BITS;
   localparam int NW = ((COUNT_BITS > DAMP_W) ? COUNT_BITS : DAMP_W) + 1;

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_READ   = 5'b00100,
      S_UPDATE = 5'b01000,
      S_DIVIDE = 5'b10000
   } state_type;

   function automatic logic [C-1:0] sat_inc(input logic [C-1:0] v);
      return (v == '1) ? v : C'(v + 1'b1);
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff;
   logic [DAMP_W-1:0]   damping_ff;
   logic [1:0]          op_ff;
   logic [NODE_W-1:0]   src_ff, dst_ff, qn_ff;

   logic [C-1:0]        deg_mem [NODES];
   logic [2*C-1:0]      dst_mem [NODES];
   logic [C-1:0]        deg_rd_ff;
   logic [2*C-1:0]      dst_rd_ff;

   logic                a_we, b_we;
   logic [AW-1:0]       a_wa, b_wa, b_ra;
   logic [C-1:0]        a_wd;
   logic [2*C-1:0]      b_wd;

   logic src_ok, dst_ok, qn_ok;
   logic [AW-1:0] src_idx, dst_idx, qn_idx;
   logic [C-1:0] deg_eff, in_v, fill_v;
   logic place_err, div_start, div_done;
   logic [NW-1:0] div_quot;

   logic [INDEX_W-1:0] row_ff, col_ff;
   logic [SLOT_W-1:0]  slot_ff;

   logic                       rsp_valid_ff, rsp_kind_ff, rsp_error_ff;
   logic [INDEX_W-1:0]         rsp_row_ff, rsp_col_ff;
   logic [SLOT_W-1:0]          rsp_slot_ff, rsp_deg_ff;
   logic signed [WEIGHT_W-1:0] rsp_weight_ff;

   assign src_ok  = (src_ff != '0) && (32'(src_ff) <= 32'(NODES));
   assign dst_ok  = (dst_ff != '0) && (32'(dst_ff) <= 32'(NODES));
   assign qn_ok   = (qn_ff != '0) && (32'(qn_ff) <= 32'(NODES));
   assign src_idx = AW'(src_ff - 1'b1);
   assign dst_idx = AW'(dst_ff - 1'b1);
   assign qn_idx  = AW'(qn_ff - 1'b1);
   assign b_ra    = (op_ff == OP_QUERY) ? qn_idx : dst_idx;

   assign deg_eff   = src_ok ? deg_rd_ff : '0;
   assign in_v      = dst_rd_ff[2*C-1:C];
   assign fill_v    = dst_rd_ff[C-1:0];
   assign place_err = !dst_ok || (deg_eff == '0);
   assign div_start = (state_ff == S_UPDATE) && (op_ff == OP_PLACE) && !place_err;

   always_ff @(posedge clock) begin
      if (a_we) deg_mem[a_wa] <= a_wd;
      deg_rd_ff <= deg_mem[src_idx];
   end

   always_ff @(posedge clock) begin
      if (b_we) dst_mem[b_wa] <= b_wd;
      dst_rd_ff <= dst_mem[b_ra];
   end

   always_comb begin
      a_we = 1'b0;
      b_we = 1'b0;
      a_wa = src_idx;
      b_wa = dst_idx;
      a_wd = sat_inc(deg_rd_ff);
      b_wd = {sat_inc(in_v), fill_v};
      if (state_ff == S_CLEAR) begin
         a_we = 1'b1;
         b_we = 1'b1;
         a_wa = clr_ff;
         b_wa = clr_ff;
         a_wd = '0;
         b_wd = '0;
      end else if (state_ff == S_UPDATE) begin
         if (op_ff == OP_COUNT && src_ok && dst_ok) begin
            a_we = 1'b1;
            b_we = 1'b1;
         end else if (op_ff == OP_PLACE && dst_ok) begin
            b_we = 1'b1;
            b_wd = {in_v, sat_inc(fill_v)};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (clr_ff == AW'(NODES - 1)) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = S_READ;
         S_READ:   state_in = S_UPDATE;
         S_UPDATE: state_in = div_start ? S_DIVIDE : S_IDLE;
         S_DIVIDE: if (div_done) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         damping_ff   <= DAMPING_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (psel && penable && pwrite && paddr[2] == REG_DAMPING)
            damping_ff <= pwdata[DAMP_W-1:0];
         if (state_ff == S_UPDATE && (op_ff == OP_QUERY || (op_ff == OP_PLACE && place_err)))
            rsp_valid_ff <= 1'b1;
         if (state_ff == S_DIVIDE && div_done) rsp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         op_ff  <= req_opcode;
         src_ff <= req_src_node;
         dst_ff <= req_dst_node;
         qn_ff  <= req_query_node;
      end
      if (state_ff == S_UPDATE) begin
         row_ff  <= dst_ok ? INDEX_W'(dst_ff - 1'b1) : '0;
         col_ff  <= src_ok ? INDEX_W'(src_ff - 1'b1) : '0;
         slot_ff <= dst_ok ? SLOT_W'(fill_v) : '0;
         if (op_ff == OP_QUERY) begin
            rsp_kind_ff   <= KIND_DEGREE;
            rsp_row_ff    <= '0;
            rsp_col_ff    <= '0;
            rsp_slot_ff   <= '0;
            rsp_weight_ff <= '0;
            rsp_error_ff  <= 1'b0;
            rsp_deg_ff    <= qn_ok ? SLOT_W'(in_v) : '0;
         end else begin
            // error entries skip the divider
            rsp_kind_ff   <= KIND_ENTRY;
            rsp_row_ff    <= dst_ok ? INDEX_W'(dst_ff - 1'b1) : '0;
            rsp_col_ff    <= src_ok ? INDEX_W'(src_ff - 1'b1) : '0;
            rsp_slot_ff   <= dst_ok ? SLOT_W'(fill_v) : '0;
            rsp_weight_ff <= '0;
            rsp_error_ff  <= 1'b1;
            rsp_deg_ff    <= '0;
         end
      end else if (state_ff == S_DIVIDE && div_done) begin
         rsp_kind_ff   <= KIND_ENTRY;
         rsp_row_ff    <= row_ff;
         rsp_col_ff    <= col_ff;
         rsp_slot_ff   <= slot_ff;
         rsp_weight_ff <= WEIGHT_W'(-WEIGHT_W'(div_quot));
         rsp_error_ff  <= 1'b0;
         rsp_deg_ff    <= '0;
      end
   end

   elcs_div #(
      .NUM_BITS   (NW),
      .COUNT_BITS (C)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (NW'(damping_ff) + NW'(deg_eff >> 1)),
      .den   (deg_eff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_row_index    = rsp_row_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_weight       = rsp_weight_ff;
   assign rsp_in_degree    = rsp_deg_ff;
   assign rsp_error        = rsp_error_ff;
   assign pready           = 1'b1;
   assign prdata           = (paddr[2] == REG_DAMPING) ? 32'(damping_ff) : '0;

`ifndef SYNTHESIS
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid) else $error("response right after transfer");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than a cycle");
   a_div_in_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVIDE)) else $error("quotient outside divide");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!a_we && !b_we)) else $error("memory write while idle");
`endif
endmodule
